[sv/ptsb_pkg.sv]
package ptsb_pkg;

    localparam int TA_MAX      = 64;
    localparam int TD_MAX      = 64;
    localparam int CFG_W       = 7;
    localparam int COORD_W     = 16;
    localparam int XCOL_W      = COORD_W - 3;
    localparam int COL_W       = $clog2(TA_MAX);
    localparam int TROW_W      = $clog2(TD_MAX);
    localparam int TILE_W      = $clog2(TA_MAX * TD_MAX);
    localparam int WORD_AW     = TILE_W + 3;
    localparam int STORE_WORDS = 8 * TA_MAX * TD_MAX;
    localparam int SPR_W       = 64;
    localparam int IN_TDATA_W  = 168;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [1:0] {
        FUNC_PLOT = 2'd0,
        FUNC_SPR1 = 2'd1,
        FUNC_SPR2 = 2'd2,
        FUNC_READ = 2'd3
    } t_func;

    // Blending table: row is the sprite pixel channel, column the color mode.
    localparam logic [1:0] BLEND_TAB [0:3][0:15] = '{
        '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1,
          2'd2, 2'd2, 2'd0, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0},
        '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
          2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1,
          2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1},
        '{2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2,
          2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2}
    };

    // One bit per color mode: a channel-zero pixel is still drawn when set.
    localparam logic [15:0] OPAQUE = 16'h7BDF;

    typedef struct packed {
        logic               we;
        logic               re;
        logic               layer;
        logic [WORD_AW-1:0] addr;
        logic [15:0]        wdata;
    } t_store_req;

    typedef struct packed {
        logic               ok;
        logic [WORD_AW-1:0] addr;
    } t_addr_res;

    typedef struct packed {
        t_func       func;
        logic [3:0]  color;
        logic [2:0]  shift;
        logic        second;
        logic        flip_x;
        logic [7:0]  row_lo;
        logic [7:0]  row_hi;
    } t_merge_ctl;

    function automatic logic [1:0] plot_value(input logic [3:0] color);
        logic [1:0] v;
        v[0] = !(color == 4'd0 || color == 4'd2);
        v[1] = !(color == 4'd0 || color == 4'd1);
        return v;
    endfunction

endpackage

[sv/ptsb_addr_unit.sv]
module ptsb_addr_unit (
    input  logic                         i_clk,
    input  logic [ptsb_pkg::XCOL_W-1:0]  i_col,
    input  logic [ptsb_pkg::COORD_W-1:0] i_row,
    input  logic [ptsb_pkg::CFG_W-1:0]   i_tiles_across,
    input  logic [ptsb_pkg::CFG_W-1:0]   i_tiles_down,
    output ptsb_pkg::t_addr_res          o_res
);

    localparam int PROD_W = ptsb_pkg::TROW_W + ptsb_pkg::CFG_W;

    logic [PROD_W-1:0]           w_prod;
    logic [PROD_W-1:0]           w_sum;
    logic                        w_ok;
    ptsb_pkg::t_addr_res         r_res;

    always_comb begin
        w_prod = PROD_W'(i_row[ptsb_pkg::TROW_W+2:3]) * PROD_W'(i_tiles_across);
        w_sum  = w_prod + PROD_W'(i_col[ptsb_pkg::COL_W-1:0]);
        w_ok   = (i_col < ptsb_pkg::XCOL_W'(i_tiles_across))
              && (i_row[ptsb_pkg::COORD_W-1:3] < ptsb_pkg::XCOL_W'(i_tiles_down));
    end

    always_ff @(posedge i_clk) begin
        r_res.ok   <= w_ok;
        r_res.addr <= {ptsb_pkg::TILE_W'(w_sum), i_row[2:0]};
    end

    assign o_res = r_res;

endmodule

[sv/ptsb_row_merge.sv]
module ptsb_row_merge (
    input  ptsb_pkg::t_merge_ctl i_ctl,
    input  logic [15:0]          i_old,
    output logic [15:0]          o_new
);

    always_comb begin
        logic [2:0] d;
        logic [2:0] h;
        logic [1:0] ch;
        logic       hit;
        logic [1:0] val;
        o_new = i_old;
        for (int p = 0; p < 8; p++) begin
            d  = 3'(p) - i_ctl.shift;
            h  = i_ctl.flip_x ? ~d : d;
            ch = {(i_ctl.func == ptsb_pkg::FUNC_SPR2) && i_ctl.row_hi[~h],
                  i_ctl.row_lo[~h]};
            if (i_ctl.func == ptsb_pkg::FUNC_PLOT) begin
                hit = (3'(p) == i_ctl.shift);
                val = ptsb_pkg::plot_value(i_ctl.color);
            end else begin
                hit = (i_ctl.second ? (3'(p) < i_ctl.shift) : (3'(p) >= i_ctl.shift))
                   && (ch != 2'd0 || ptsb_pkg::OPAQUE[i_ctl.color]);
                val = ptsb_pkg::BLEND_TAB[ch][i_ctl.color];
            end
            if (hit) begin
                o_new[7 - p]  = val[0];
                o_new[15 - p] = val[1];
            end
        end
    end

endmodule

[sv/ptsb_store.sv]
module ptsb_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptsb_pkg::t_store_req i_req,
    output logic [15:0]          o_rdata,
    output logic                 o_busy
);

    localparam int AW = ptsb_pkg::WORD_AW;

    // Each word holds one tile row: low plane in bits 7:0, high plane in 15:8.
    logic [15:0]   r_bg_mem [0:ptsb_pkg::STORE_WORDS-1];
    logic [15:0]   r_fg_mem [0:ptsb_pkg::STORE_WORDS-1];
    logic [15:0]   r_bg_q;
    logic [15:0]   r_fg_q;
    logic          r_layer_q;
    logic          r_clearing;
    logic          n_clearing;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] n_clr_addr;

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(ptsb_pkg::STORE_WORDS - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_bg_mem[r_clr_addr] <= 16'h0000;
            r_fg_mem[r_clr_addr] <= 16'h0000;
        end else if (i_req.we) begin
            if (i_req.layer) begin
                r_fg_mem[i_req.addr] <= i_req.wdata;
            end else begin
                r_bg_mem[i_req.addr] <= i_req.wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_bg_q    <= r_bg_mem[i_req.addr];
            r_fg_q    <= r_fg_mem[i_req.addr];
            r_layer_q <= i_req.layer;
        end
    end

    assign o_rdata = r_layer_q ? r_fg_q : r_bg_q;
    assign o_busy  = r_clearing;

endmodule

[sv/planar_tile_sprite_blitter.sv]
// Two-layer 2-bit planar tile framebuffer with pixel plot, pixel read and
// 8x8 sprite draw commands.
// Input items arrive on s_axis; each item gives exactly one result item on
// m_axis. Configuration is written through i_cfg_we, i_cfg_index and
// i_cfg_data; the user must write it only while the block is idle, which
// the block itself does not enforce. Index 0 sets the width in tiles and
// index 1 the height in tiles. A plot or read item whose coordinate lies
// on screen passes through the states S_ADDR, S_RD, S_WR and S_OUT; off
// screen it skips S_WR. A sprite item visits 8 tile row bytes, or 16 when
// its column is not tile aligned. No item is accepted until the previous
// one has left S_OUT. The single port of the frame store sets the pace:
// every on-screen byte is read in S_RD and written back in the S_WR state
// that follows, while one shared address unit computes the next address.
// After reset both layers are cleared, one row word of each layer per cycle,
// over all 32768 row words; no item is accepted during that pass.
// One output register holds the result. The block accepts the next item
// while a result waits, and holds its own finished result until the output
// register is free.
module planar_tile_sprite_blitter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [ptsb_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pos_x, pos_y, color_mode, flip_x, flip_y, sprite_low_plane,
    // sprite_high_plane, zero fill
    input  logic [ptsb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func, layer_select
    input  logic [ptsb_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // read_value, in_range, zero fill
    output logic [ptsb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int CW = ptsb_pkg::CFG_W;
    localparam logic REG_TILES_ACROSS = 1'b0;
    localparam logic REG_TILES_DOWN   = 1'b1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_ADDR  = 6'b000100,
        S_RD    = 6'b001000,
        S_WR    = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    function automatic logic [CW-1:0] clamp_tiles(input logic [CW-1:0] v,
                                                  input logic [CW-1:0] lim);
        logic [CW-1:0] r;
        r = v;
        if (v == '0) begin
            r = CW'(1);
        end else if (v > lim) begin
            r = lim;
        end
        return r;
    endfunction

    t_state                          r_state;
    t_state                          n_state;
    logic [CW-1:0]                   r_tiles_across;
    logic [CW-1:0]                   r_tiles_down;

    ptsb_pkg::t_func                 r_func;
    logic                            r_layer;
    logic [ptsb_pkg::COORD_W-1:0]    r_x;
    logic [ptsb_pkg::COORD_W-1:0]    r_y;
    logic [3:0]                      r_color;
    logic                            r_fx;
    logic                            r_fy;
    logic [ptsb_pkg::SPR_W-1:0]      r_lo;
    logic [ptsb_pkg::SPR_W-1:0]      r_hi;

    logic [2:0]                      r_e;
    logic                            r_k;
    logic [7:0]                      r_cur_lo;
    logic [7:0]                      r_cur_hi;
    logic                            r_cur_k;
    logic                            r_cur_last;
    logic [ptsb_pkg::WORD_AW-1:0]    r_cur_addr;

    logic [1:0]                      r_res_value;
    logic                            r_res_in_range;
    logic                            r_m_valid;
    logic [1:0]                      r_m_value;
    logic                            r_m_in_range;

    logic                            w_accept;
    logic                            w_sprite;
    logic                            w_last;
    logic                            w_advance;
    logic                            w_out_load;
    logic [2:0]                      w_byte;
    logic [7:0]                      w_row_lo;
    logic [7:0]                      w_row_hi;
    logic [ptsb_pkg::XCOL_W-1:0]     w_col;
    logic [ptsb_pkg::COORD_W-1:0]    w_row;
    ptsb_pkg::t_addr_res             w_addr_res;
    ptsb_pkg::t_store_req            w_req;
    ptsb_pkg::t_merge_ctl            w_merge_ctl;
    logic [15:0]                     w_rdata;
    logic [15:0]                     w_new;
    logic                            w_clr_busy;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_sprite      = (r_func == ptsb_pkg::FUNC_SPR1) || (r_func == ptsb_pkg::FUNC_SPR2);
    assign w_last        = !w_sprite || (r_e == 3'd7 && (r_k || r_x[2:0] == 3'd0));
    assign w_out_load    = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    assign w_col    = r_x[ptsb_pkg::COORD_W-1:3] + ptsb_pkg::XCOL_W'(r_k);
    assign w_row    = r_y + ptsb_pkg::COORD_W'(r_e);
    assign w_byte   = r_fy ? r_e : ~r_e;
    assign w_row_lo = r_lo[{w_byte, 3'b000} +: 8];
    assign w_row_hi = r_hi[{w_byte, 3'b000} +: 8];

    ptsb_addr_unit u_addr (
        .i_clk          (i_clk),
        .i_col          (w_col),
        .i_row          (w_row),
        .i_tiles_across (r_tiles_across),
        .i_tiles_down   (r_tiles_down),
        .o_res          (w_addr_res)
    );

    always_comb begin
        w_merge_ctl.func   = r_func;
        w_merge_ctl.color  = r_color;
        w_merge_ctl.shift  = r_x[2:0];
        w_merge_ctl.second = r_cur_k;
        w_merge_ctl.flip_x = r_fx;
        w_merge_ctl.row_lo = r_cur_lo;
        w_merge_ctl.row_hi = r_cur_hi;
    end

    ptsb_row_merge u_merge (
        .i_ctl (w_merge_ctl),
        .i_old (w_rdata),
        .o_new (w_new)
    );

    always_comb begin
        w_req.re    = (r_state == S_RD) && w_addr_res.ok;
        w_req.we    = (r_state == S_WR) && (r_func != ptsb_pkg::FUNC_READ);
        w_req.layer = r_layer;
        w_req.addr  = (r_state == S_WR) ? r_cur_addr : w_addr_res.addr;
        w_req.wdata = w_new;
    end

    ptsb_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rdata (w_rdata),
        .o_busy  (w_clr_busy)
    );

    always_comb begin
        n_state   = r_state;
        w_advance = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (!w_clr_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                w_advance = 1'b1;
                n_state   = S_RD;
            end
            S_RD: begin
                if (w_addr_res.ok) begin
                    n_state = S_WR;
                end else if (r_cur_last) begin
                    n_state = S_OUT;
                end else begin
                    w_advance = 1'b1;
                end
            end
            S_WR: begin
                if (r_cur_last) begin
                    n_state = S_OUT;
                end else begin
                    w_advance = 1'b1;
                    n_state   = S_RD;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_tiles_across <= clamp_tiles(CW'(64), CW'(ptsb_pkg::TA_MAX));
            r_tiles_down   <= clamp_tiles(CW'(64), CW'(ptsb_pkg::TD_MAX));
            r_m_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == REG_TILES_ACROSS) begin
                r_tiles_across <= clamp_tiles(i_cfg_data, CW'(ptsb_pkg::TA_MAX));
            end
            if (i_cfg_we && i_cfg_index == REG_TILES_DOWN) begin
                r_tiles_down <= clamp_tiles(i_cfg_data, CW'(ptsb_pkg::TD_MAX));
            end
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func         <= ptsb_pkg::t_func'(s_axis_tuser[1:0]);
            r_layer        <= s_axis_tuser[2];
            r_x            <= s_axis_tdata[15:0];
            r_y            <= s_axis_tdata[31:16];
            r_color        <= s_axis_tdata[35:32];
            r_fx           <= s_axis_tdata[36];
            r_fy           <= s_axis_tdata[37];
            r_lo           <= s_axis_tdata[101:38];
            r_hi           <= s_axis_tdata[165:102];
            r_e            <= 3'd0;
            r_k            <= 1'b0;
            r_res_value    <= 2'd0;
            r_res_in_range <= 1'b0;
        end
        if (w_advance) begin
            r_cur_lo   <= w_row_lo;
            r_cur_hi   <= w_row_hi;
            r_cur_k    <= r_k;
            r_cur_last <= w_last;
            if (!r_k && r_x[2:0] != 3'd0) begin
                r_k <= 1'b1;
            end else begin
                r_k <= 1'b0;
                r_e <= r_e + 3'd1;
            end
        end
        if (r_state == S_RD) begin
            r_cur_addr <= w_addr_res.addr;
            if (!w_sprite) begin
                r_res_in_range <= w_addr_res.ok;
            end
        end
        if (r_state == S_WR && r_func == ptsb_pkg::FUNC_READ) begin
            r_res_value <= {w_rdata[{1'b1, ~r_x[2:0]}], w_rdata[{1'b0, ~r_x[2:0]}]};
        end
        if (w_out_load) begin
            r_m_value    <= r_res_value;
            r_m_in_range <= r_res_in_range;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'b00000, r_m_in_range, r_m_value};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("item accepted while the previous one is still in work");

    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> !w_clr_busy)
        else $error("store access during the clearing pass");

    a_value_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_func != ptsb_pkg::FUNC_READ) |-> (r_res_value == 2'd0))
        else $error("nonzero read value for a command that does not read");

    a_sprite_no_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_sprite) |-> !r_res_in_range)
        else $error("sprite command reports an in-range coordinate");

endmodule

[tb/tb_planar_tile_sprite_blitter.sv]
`timescale 1ns / 100ps

module tb_planar_tile_sprite_blitter;

    typedef struct packed {
        bit [1:0] value;
        bit       in_range;
    } t_pix_result;

    class framebuffer_scoreboard;
        bit [7:0]    planes [0:1][0:65535];
        int unsigned cols;
        int unsigned rows;
        t_pix_result pending_results [$];
        int          errors;
        int          checked;

        function new();
            cols = 64;
            rows = 64;
            errors = 0;
            checked = 0;
        endfunction

        function int unsigned clamp_tiles(bit [6:0] v, int unsigned max_tiles);
            if (v == 0) return 1;
            if (v > max_tiles) return max_tiles;
            return v;
        endfunction

        function void set_reg(bit idx, bit [6:0] v);
            if (idx == 1'b0) cols = clamp_tiles(v, 64);
            else rows = clamp_tiles(v, 64);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Pixel color chosen by a sprite channel and a color mode.
        function bit [1:0] mix(bit [1:0] ch, bit [3:0] c);
            bit [31:0] row;
            case (ch)
                2'd0: row = 32'h3F8A_5100;
                2'd1: row = 32'hE4E4_E4E4;
                2'd2: row = 32'h7979_7979;
                default: row = 32'h9E9E_9E9E;
            endcase
            return row[2*c +: 2];
        endfunction

        function bit locate(int unsigned x, int unsigned y, output int unsigned idx);
            idx = 0;
            if (x >= 8 * cols || y >= 8 * rows) return 0;
            idx = (y & 7) + ((x >> 3) + (y >> 3) * cols) * 16;
            if (idx + 8 >= 65536) return 0;
            return 1;
        endfunction

        function bit put_pixel(bit lyr, int unsigned x, int unsigned y, bit [3:0] c);
            int unsigned idx;
            bit [7:0]    m;
            if (!locate(x, y, idx)) return 0;
            m = 8'h80 >> (x & 7);
            if (c == 0 || c == 2) planes[lyr][idx] &= ~m;
            else planes[lyr][idx] |= m;
            if (c == 0 || c == 1) planes[lyr][idx + 8] &= ~m;
            else planes[lyr][idx + 8] |= m;
            return 1;
        endfunction

        function void blit(bit lyr, bit [15:0] x0, bit [15:0] y0, bit [63:0] lo,
                           bit [63:0] hi, bit two_bpp, bit [3:0] c, bit fx, bit fy);
            bit [7:0]  rlo;
            bit [7:0]  rhi;
            bit [1:0]  ch;
            bit [15:0] px;
            bit [15:0] py;
            bit        dummy;
            bit [15:0] opaque;
            opaque = 16'h7BDF;
            for (int v = 0; v < 8; v++) begin
                rlo = lo[56 - 8 * v +: 8];
                rhi = hi[56 - 8 * v +: 8];
                for (int h = 0; h < 8; h++) begin
                    ch = {two_bpp & rhi[7 - h], rlo[7 - h]};
                    if (ch != 0 || opaque[c]) begin
                        px = x0 + 16'(fx ? 7 - h : h);
                        py = y0 + 16'(fy ? 7 - v : v);
                        dummy = put_pixel(lyr, px, py, {2'b00, mix(ch, c)});
                    end
                end
            end
        endfunction

        function void note_command(ptsb_pkg::t_func f, bit lyr, bit [15:0] x,
                                   bit [15:0] y, bit [3:0] c, bit fx, bit fy,
                                   bit [63:0] lo, bit [63:0] hi);
            t_pix_result r;
            int unsigned idx;
            bit [2:0]    s;
            r = '0;
            case (f)
                ptsb_pkg::FUNC_PLOT: r.in_range = put_pixel(lyr, x, y, c);
                ptsb_pkg::FUNC_SPR1: blit(lyr, x, y, lo, hi, 1'b0, c, fx, fy);
                ptsb_pkg::FUNC_SPR2: blit(lyr, x, y, lo, hi, 1'b1, c, fx, fy);
                default: begin
                    if (locate(x, y, idx)) begin
                        s = 3'(7 - (x & 7));
                        r.value = {planes[lyr][idx + 8][s], planes[lyr][idx][s]};
                        r.in_range = 1'b1;
                    end
                end
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [7:0] d);
            t_pix_result e;
            if (pending_results.size() == 0) begin
                $error("unexpected result item, tdata %h", d);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            checked++;
            if (d[1:0] !== e.value) begin
                $error("read_value: expected %0d, actual %0d", e.value, d[1:0]);
                errors++;
            end
            if (d[2] !== e.in_range) begin
                $error("in_range: expected %0d, actual %0d", e.in_range, d[2]);
                errors++;
            end
            if (d[7:3] !== 5'd0) begin
                $error("zero_fill: expected 0, actual %0d", d[7:3]);
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic                             i_cfg_index = 1'b0;
    logic [ptsb_pkg::CFG_W-1:0]       i_cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [ptsb_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [ptsb_pkg::IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b1;
    logic [ptsb_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    framebuffer_scoreboard sb = new();
    bit          calm = 1'b0;
    int          n_plot = 0;
    int          n_sprite = 0;
    int          n_read = 0;
    int          n_geometry = 0;
    bit [15:0]   last_spr_x = 0;
    bit [15:0]   last_spr_y = 0;

    planar_tile_sprite_blitter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_cmd(ptsb_pkg::t_func f, bit lyr, bit [15:0] x, bit [15:0] y,
                            bit [3:0] c, bit fx, bit fy, bit [63:0] lo, bit [63:0] hi);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, hi, lo, fy, fx, c, y, x};
        s_axis_tuser  <= {lyr, f};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(f, lyr, x, y, c, fx, fy, lo, hi);
        case (f)
            ptsb_pkg::FUNC_PLOT: n_plot++;
            ptsb_pkg::FUNC_READ: n_read++;
            default: begin
                n_sprite++;
                last_spr_x = x;
                last_spr_y = y;
            end
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(bit idx, bit [6:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic bit [15:0] pick_coord(int unsigned span);
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) return 16'($urandom_range(0, span + 7));
        if (r == 8) return 16'($urandom_range(65528, 65535));
        return 16'($urandom);
    endfunction

    function automatic bit [63:0] pick_plane();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 64'd0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic random_cmd();
        int              r;
        ptsb_pkg::t_func f;
        bit [15:0]       x;
        bit [15:0]       y;
        r = $urandom_range(0, 99);
        if (r < 25) f = ptsb_pkg::FUNC_PLOT;
        else if (r < 45) f = ptsb_pkg::FUNC_SPR1;
        else if (r < 70) f = ptsb_pkg::FUNC_SPR2;
        else f = ptsb_pkg::FUNC_READ;
        x = pick_coord(8 * sb.cols);
        y = pick_coord(8 * sb.rows);
        if (f == ptsb_pkg::FUNC_READ && $urandom_range(0, 1) == 1) begin
            x = last_spr_x + 16'($urandom_range(0, 7));
            y = last_spr_y + 16'($urandom_range(0, 7));
        end
        send_cmd(f, 1'($urandom), x, y, 4'($urandom), 1'($urandom), 1'($urandom),
                 pick_plane(), pick_plane());
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) m_axis_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 8);
                m_axis_tready <= 1'b0;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_planar_tile_sprite_blitter: FAIL");
        $finish;
    end

    initial begin
        int geo_a [8];
        int geo_d [8];
        geo_a = '{1, 0, 127, 3, 64, 1, 9, 64};
        geo_d = '{1, 0, 127, 5, 1, 64, 2, 64};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        write_reg(1'b0, 7'd64);
        write_reg(1'b1, 7'd64);

        send_cmd(ptsb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_PLOT, 0, 0, 0, 1, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_PLOT, 0, 1, 0, 2, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_READ, 0, 1, 0, 0, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_PLOT, 0, 7, 7, 15, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_READ, 0, 7, 7, 0, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_PLOT, 0, 7, 7, 0, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_READ, 0, 7, 7, 0, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_PLOT, 1, 511, 511, 3, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_READ, 1, 511, 511, 0, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_READ, 0, 511, 511, 0, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_PLOT, 0, 512, 5, 3, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_READ, 0, 512, 5, 0, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_READ, 0, 5, 16'hFFFF, 0, 0, 0, 0, 0);
        // The sprite straddles the wrap of both coordinates.
        send_cmd(ptsb_pkg::FUNC_SPR1, 0, 16'hFFFC, 16'hFFFC, 1, 1, 0, '1, 0);
        send_cmd(ptsb_pkg::FUNC_READ, 0, 2, 2, 0, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_SPR2, 1, 8, 16, 4, 1, 1, 64'hF0F0_F0F0_F0F0_F0F0,
                 64'hCCCC_CCCC_CCCC_CCCC);
        send_cmd(ptsb_pkg::FUNC_READ, 1, 8, 16, 0, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_READ, 1, 15, 23, 0, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_SPR1, 1, 8, 16, 0, 0, 0, 0, '1);
        send_cmd(ptsb_pkg::FUNC_SPR1, 1, 8, 16, 5, 0, 0, 0, '1);
        send_cmd(ptsb_pkg::FUNC_SPR2, 0, 100, 100, 15, 0, 0, '1, 0);
        send_cmd(ptsb_pkg::FUNC_READ, 0, 103, 104, 0, 0, 0, 0, 0);
        send_cmd(ptsb_pkg::FUNC_READ, 1, 9, 17, 0, 0, 0, 0, 0);

        for (int p = 0; p < 8; p++) begin
            write_reg(1'b0, 7'(geo_a[p]));
            write_reg(1'b1, 7'(geo_d[p]));
            n_geometry++;
            if (p == 7) calm = 1'b1;
            for (int k = 0; k < 125; k++) begin
                if (p == 2 && k == 60) drain();
                random_cmd();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Sent %0d plots, %0d sprites and %0d reads; %0d results checked.",
                 n_plot, n_sprite, n_read, sb.checked);
        $display("Screen geometries visited after the default: %0d, clamped ones included.",
                 n_geometry);
        if (sb.errors == 0) begin
            $display("tb_planar_tile_sprite_blitter: PASS");
        end else begin
            $display("tb_planar_tile_sprite_blitter: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
sv/ptsb_pkg.sv
sv/ptsb_addr_unit.sv
sv/ptsb_row_merge.sv
sv/ptsb_store.sv
sv/planar_tile_sprite_blitter.sv
tb/tb_planar_tile_sprite_blitter.sv
